FILE: hw/rtl/ihp_pkg.sv
// ihp_pkg: shared types, widths and codes of the indexed max-heap unit
// no dependencies; used by every file under hw/rtl
package ihp_pkg;

  localparam int CAPACITY   = 1024;
  localparam int PRIO_W     = 32;
  localparam int TAG_W      = 10;
  localparam int TAG_SPACE  = 1 << TAG_W;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 10;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_EXT_MAX = 2'd1,
    MODE_EXT_POS = 2'd2,
    MODE_LOCATE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_CHK,
    S_RM_RD,
    S_RM_TAG,
    S_UP_RD,
    S_UP_CMP,
    S_UP_SW2,
    S_DN_RD,
    S_DN_CMP,
    S_DN_SW2
  } state_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } heap_entry_t;

  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
  } tag_entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    heap_entry_t       data;
  } heap_wr_t;

  typedef struct packed {
    logic             en;
    logic [TAG_W-1:0] addr;
    tag_entry_t       data;
  } tag_wr_t;

endpackage

FILE: hw/rtl/indexed_max_heap_unit.sv
// indexed_max_heap_unit: sequencer for an indexed binary max-heap
// depends on ihp_pkg, ihp_heap_mem, ihp_tag_mem
//
// channel   direction  handshake          fields
// command   in         start & !busy      mode, priority_in, entry_tag, position
// result    out        done (one cycle)   status, priority_out, tag_out, slot_out,
//                                         entry_count
//
// steps: locate and refused commands end after the check; an insert writes at the
// end of the heap and rises level by level; a removal moves the last entry into
// the freed slot (and ends there when that slot was the last), then rises and sinks
// it level by level; each level is a heap memory read, a compare and two swap
// writes through the single heap write port
// reset: after rst the tag memory is swept clear, one entry a cycle, all 1024
// entries with busy high
// stalls: busy stays high from accept until the done beat; results cannot be held off
module indexed_max_heap_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 mode,
  input  logic [ihp_pkg::PRIO_W-1:0] priority_in,
  input  logic [ihp_pkg::TAG_W-1:0]  entry_tag,
  input  logic [ihp_pkg::POS_W-1:0]  position,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [ihp_pkg::PRIO_W-1:0] priority_out,
  output logic [ihp_pkg::TAG_W-1:0]  tag_out,
  output logic [ihp_pkg::SLOT_W-1:0] slot_out,
  output logic [ihp_pkg::CNT_W-1:0]  entry_count
);
  import ihp_pkg::*;

  state_t              state, state_next;
  logic [TAG_W-1:0]    clr_cnt;
  mode_t               mode_r;
  logic [PRIO_W-1:0]   prio_r;
  logic [TAG_W-1:0]    tag_r;
  logic [POS_W-1:0]    pos_r;
  logic [SLOT_W-1:0]   s;
  heap_entry_t         cur;
  logic [CNT_W-1:0]    fill;

  heap_wr_t            h_wr;
  logic [SLOT_W-1:0]   h_ra, h_rb;
  heap_entry_t         h_da, h_db;
  tag_wr_t             t_wr;
  logic [TAG_W-1:0]    t_ra;
  tag_entry_t          t_rd;

  // derived indexes and decisions
  logic [SLOT_W-1:0]   up;
  logic [CNT_W-1:0]    last, lc, rc, rm_slot;
  logic                is_rm, full, ins_ok, rm_ok;
  logic                up_swap, dn_right, dn_swap;
  heap_entry_t         big;
  logic [SLOT_W-1:0]   big_idx;

  assign up      = (s - SLOT_W'(1)) >> 1;
  assign last    = fill - CNT_W'(1);
  assign lc      = {s, 1'b1};
  assign rc      = lc + CNT_W'(1);
  assign is_rm   = (mode_r == MODE_EXT_MAX) || (mode_r == MODE_EXT_POS);
  assign rm_slot = (mode_r == MODE_EXT_MAX) ? '0 : CNT_W'(pos_r);
  assign full    = (fill >= CNT_W'(CAPACITY)) || t_rd.present;
  assign ins_ok  = !full;
  assign rm_ok   = rm_slot < fill;
  assign up_swap = cur.prio > h_da.prio;
  assign dn_right = (rc < fill) && (h_db.prio > h_da.prio);
  assign big     = dn_right ? h_db : h_da;
  assign big_idx = dn_right ? rc[SLOT_W-1:0] : lc[SLOT_W-1:0];
  assign dn_swap = cur.prio < big.prio;

  ihp_heap_mem u_heap (
    .clk     (clk),
    .wr      (h_wr),
    .raddr_a (h_ra),
    .raddr_b (h_rb),
    .rdata_a (h_da),
    .rdata_b (h_db)
  );

  ihp_tag_mem u_tag (
    .clk   (clk),
    .wr    (t_wr),
    .raddr (t_ra),
    .rdata (t_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLR:    if (clr_cnt == '1) state_next = S_IDLE;
      S_IDLE:   if (start) state_next = S_CHK;
      S_CHK: begin
        case (mode_r)
          MODE_INSERT: state_next = ins_ok ? S_UP_RD : S_IDLE;
          MODE_LOCATE: state_next = S_IDLE;
          default:     state_next = rm_ok ? S_RM_RD : S_IDLE;
        endcase
      end
      S_RM_RD:  state_next = (CNT_W'(s) != last) ? S_RM_TAG : S_IDLE;
      S_RM_TAG: state_next = S_UP_RD;
      S_UP_RD: begin
        if (s != '0)   state_next = S_UP_CMP;
        else if (is_rm) state_next = S_DN_RD;
        else           state_next = S_IDLE;
      end
      S_UP_CMP: begin
        if (up_swap)    state_next = S_UP_SW2;
        else if (is_rm) state_next = S_DN_RD;
        else            state_next = S_IDLE;
      end
      S_UP_SW2: state_next = S_UP_RD;
      S_DN_RD:  state_next = (lc >= fill) ? S_IDLE : S_DN_CMP;
      S_DN_CMP: state_next = dn_swap ? S_DN_SW2 : S_IDLE;
      S_DN_SW2: state_next = S_DN_RD;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    h_wr = '0;
    t_wr = '0;
    h_ra = s;
    h_rb = s;
    t_ra = entry_tag;
    case (state)
      S_CLR: begin
        t_wr.en   = 1'b1;
        t_wr.addr = clr_cnt;
      end
      S_CHK: begin
        if (mode_r == MODE_INSERT) begin
          if (ins_ok) begin
            h_wr.en   = 1'b1;
            h_wr.addr = fill[SLOT_W-1:0];
            h_wr.data = '{prio: prio_r, tag: tag_r};
            t_wr.en   = 1'b1;
            t_wr.addr = tag_r;
            t_wr.data = '{present: 1'b1, slot: fill[SLOT_W-1:0]};
          end
        end else begin
          h_ra = rm_slot[SLOT_W-1:0];
          h_rb = last[SLOT_W-1:0];
        end
      end
      S_RM_RD: begin
        t_wr.en   = 1'b1;
        t_wr.addr = h_da.tag;
        if (CNT_W'(s) != last) begin
          h_wr.en   = 1'b1;
          h_wr.addr = s;
          h_wr.data = h_db;
        end
      end
      S_RM_TAG: begin
        t_wr.en   = 1'b1;
        t_wr.addr = cur.tag;
        t_wr.data = '{present: 1'b1, slot: s};
      end
      S_UP_RD:  h_ra = up;
      S_UP_CMP: begin
        if (up_swap) begin
          h_wr.en   = 1'b1;
          h_wr.addr = s;
          h_wr.data = h_da;
          t_wr.en   = 1'b1;
          t_wr.addr = h_da.tag;
          t_wr.data = '{present: 1'b1, slot: s};
        end
      end
      S_DN_RD: begin
        h_ra = lc[SLOT_W-1:0];
        h_rb = rc[SLOT_W-1:0];
      end
      S_DN_CMP: begin
        if (dn_swap) begin
          h_wr.en   = 1'b1;
          h_wr.addr = s;
          h_wr.data = big;
          t_wr.en   = 1'b1;
          t_wr.addr = big.tag;
          t_wr.data = '{present: 1'b1, slot: s};
        end
      end
      S_UP_SW2, S_DN_SW2: begin
        h_wr.en   = 1'b1;
        h_wr.addr = s;
        h_wr.data = cur;
        t_wr.en   = 1'b1;
        t_wr.addr = cur.tag;
        t_wr.data = '{present: 1'b1, slot: s};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      fill    <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state != S_IDLE) && (state != S_CLR) && (state_next == S_IDLE);
      if (state == S_CLR) clr_cnt <= clr_cnt + TAG_W'(1);
      if (state == S_CHK && mode_r == MODE_INSERT && ins_ok) fill <= fill + CNT_W'(1);
      if (state == S_RM_RD) fill <= last;
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          mode_r       <= mode_t'(mode);
          prio_r       <= priority_in;
          tag_r        <= entry_tag;
          pos_r        <= position;
          status       <= ST_OK;
          priority_out <= '0;
          tag_out      <= '0;
          slot_out     <= '0;
        end
      end
      S_CHK: begin
        case (mode_r)
          MODE_INSERT: begin
            if (ins_ok) begin
              s   <= fill[SLOT_W-1:0];
              cur <= '{prio: prio_r, tag: tag_r};
            end else begin
              status <= ST_FULL;
            end
          end
          MODE_LOCATE: begin
            if (t_rd.present) slot_out <= t_rd.slot;
            else              status   <= ST_ABSENT;
          end
          default: begin
            s <= rm_slot[SLOT_W-1:0];
            if (!rm_ok) status <= ST_RANGE;
          end
        endcase
      end
      S_RM_RD: begin
        priority_out <= h_da.prio;
        tag_out      <= h_da.tag;
        cur          <= h_db;
      end
      S_UP_RD: begin
        if (s == '0 && !is_rm) slot_out <= s;
      end
      S_UP_CMP: begin
        if (up_swap)     s        <= up;
        else if (!is_rm) slot_out <= s;
      end
      S_DN_CMP: begin
        if (dn_swap) s <= big_idx;
      end
      default: ;
    endcase
  end

  assign busy        = (state != S_IDLE);
  assign entry_count = fill;

  // checks on the sequencer
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(CAPACITY)) else $error("fill count beyond capacity");
  a_accept_chk: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_CHK)) else $error("accepted beat not checked");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE)) else $error("result beat while busy");
  a_refused_keep: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> $stable(fill)) else $error("refused command changed fill");
endmodule

FILE: hw/rtl/ihp_heap_mem.sv
// ihp_heap_mem: heap slot memory, one write port and two registered read ports
// depends on ihp_pkg
module ihp_heap_mem (
  input  logic                       clk,
  input  ihp_pkg::heap_wr_t          wr,
  input  logic [ihp_pkg::SLOT_W-1:0] raddr_a,
  input  logic [ihp_pkg::SLOT_W-1:0] raddr_b,
  output ihp_pkg::heap_entry_t       rdata_a,
  output ihp_pkg::heap_entry_t       rdata_b
);
  import ihp_pkg::*;

  heap_entry_t mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

FILE: hw/rtl/ihp_tag_mem.sv
// ihp_tag_mem: tag-to-slot memory with present bit, one write and one read port
// depends on ihp_pkg
module ihp_tag_mem (
  input  logic                      clk,
  input  ihp_pkg::tag_wr_t          wr,
  input  logic [ihp_pkg::TAG_W-1:0] raddr,
  output ihp_pkg::tag_entry_t       rdata
);
  import ihp_pkg::*;

  tag_entry_t mem [TAG_SPACE];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

FILE: bench/tb_indexed_max_heap_unit.sv
// tb_indexed_max_heap_unit: self-checking bench for the indexed max-heap unit
// depends on ihp_pkg and indexed_max_heap_unit; a behavioral heap predicts every done beat
module tb_indexed_max_heap_unit;
  import ihp_pkg::*;

  typedef struct {
    mode_t                   mode;
    logic [PRIO_W-1:0]       prio;
    logic [TAG_W-1:0]        tag;
    logic [POS_W-1:0]        pos;
  } heap_cmd_t;

  typedef struct {
    status_t                 status;
    logic [PRIO_W-1:0]       prio;
    logic [TAG_W-1:0]        tag;
    logic [SLOT_W-1:0]       slot;
    logic [CNT_W-1:0]        count;
  } heap_reply_t;

  logic clk, rst, start, busy, done;
  logic [1:0] mode, status;
  logic [PRIO_W-1:0] priority_in, priority_out;
  logic [TAG_W-1:0] entry_tag, tag_out;
  logic [POS_W-1:0] position;
  logic [SLOT_W-1:0] slot_out;
  logic [CNT_W-1:0] entry_count;

  indexed_max_heap_unit u_dut (.*);

  // shadow heap
  logic [PRIO_W-1:0] shadow_prio [CAPACITY];
  logic [TAG_W-1:0]  shadow_tag [CAPACITY];
  int unsigned       shadow_slot [TAG_SPACE];
  bit                shadow_present [TAG_SPACE];
  int unsigned       shadow_fill;

  heap_cmd_t   cmd_queue [$];
  heap_reply_t reply_queue [$];
  int          error_count;
  bit          stim_done;

  // plan-time mirror of tag presence, kept loosely in step with queued commands
  bit shadow_present_plan [TAG_SPACE];
  int unsigned plan_fill;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [PRIO_W-1:0] p;
    logic [TAG_W-1:0] t;
    p = shadow_prio[a]; t = shadow_tag[a];
    shadow_prio[a] = shadow_prio[b]; shadow_tag[a] = shadow_tag[b];
    shadow_prio[b] = p; shadow_tag[b] = t;
    shadow_slot[shadow_tag[a]] = a;
    shadow_slot[shadow_tag[b]] = b;
  endfunction

  function automatic int unsigned sift_up(int unsigned s);
    int unsigned up;
    while (s >= 1 && s < shadow_fill) begin
      up = (s - 1) / 2;
      if (shadow_prio[s] <= shadow_prio[up]) break;
      swap_slots(s, up);
      s = up;
    end
    return s;
  endfunction

  function automatic void sift_down(int unsigned s);
    int unsigned l, big;
    forever begin
      l = 2 * s + 1;
      if (l >= shadow_fill) break;
      big = l;
      if (l + 1 < shadow_fill && shadow_prio[l+1] > shadow_prio[l]) big = l + 1;
      if (shadow_prio[s] >= shadow_prio[big]) break;
      swap_slots(s, big);
      s = big;
    end
  endfunction

  // apply one command to the shadow heap and return the expected reply
  function automatic heap_reply_t heap_apply(heap_cmd_t c);
    heap_reply_t r;
    int unsigned s, last;
    r = '{ST_OK, '0, '0, '0, '0};
    case (c.mode)
      MODE_INSERT: begin
        if (shadow_fill >= CAPACITY || shadow_present[c.tag]) r.status = ST_FULL;
        else begin
          s = shadow_fill;
          shadow_prio[s] = c.prio; shadow_tag[s] = c.tag;
          shadow_slot[c.tag] = s; shadow_present[c.tag] = 1;
          shadow_fill++;
          r.slot = SLOT_W'(sift_up(s));
        end
      end
      MODE_LOCATE: begin
        if (shadow_present[c.tag]) r.slot = SLOT_W'(shadow_slot[c.tag]);
        else r.status = ST_ABSENT;
      end
      default: begin
        s = (c.mode == MODE_EXT_MAX) ? 0 : 32'(c.pos);
        if (s >= shadow_fill) r.status = ST_RANGE;
        else begin
          last = shadow_fill - 1;
          r.prio = shadow_prio[s]; r.tag = shadow_tag[s];
          shadow_present[shadow_tag[s]] = 0;
          if (s != last) begin
            shadow_prio[s] = shadow_prio[last]; shadow_tag[s] = shadow_tag[last];
            shadow_slot[shadow_tag[s]] = s;
          end
          shadow_fill = last;
          if (s < shadow_fill) sift_down(sift_up(s));
        end
      end
    endcase
    r.count = CNT_W'(shadow_fill);
    return r;
  endfunction

  function automatic heap_cmd_t make_cmd(mode_t m, logic [PRIO_W-1:0] p,
                                         int unsigned t, int unsigned q);
    heap_cmd_t c;
    c.mode = m; c.prio = p; c.tag = TAG_W'(t); c.pos = POS_W'(q);
    return c;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver: bursts of beats with random gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (rst) begin
      start <= 0; mode <= '0; priority_in <= '0; entry_tag <= '0; position <= '0;
      burst_left <= 0; gap_left <= 0;
    end else if (start && busy) begin
      // hold the beat until accepted
    end else if (gap_left > 0) begin
      start <= 0;
      gap_left <= gap_left - 1;
    end else if (cmd_queue.size() > 0) begin
      heap_cmd_t c;
      c = cmd_queue.pop_front();
      start <= 1;
      mode <= c.mode; priority_in <= c.prio; entry_tag <= c.tag; position <= c.pos;
      reply_queue = {reply_queue, heap_apply(c)};
      if (burst_left <= 0) begin
        burst_left <= $urandom_range(1, 30);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40);
      end else burst_left <= burst_left - 1;
    end else start <= 0;
  end

  // monitor: every done beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (reply_queue.size() == 0) begin
        $error("unexpected done beat");
        error_count++;
      end else begin
        heap_reply_t e;
        e = reply_queue.pop_front();
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); error_count++;
        end
        if (priority_out !== e.prio) begin
          $error("priority_out exp %0h got %0h", e.prio, priority_out); error_count++;
        end
        if (tag_out !== e.tag) begin
          $error("tag_out exp %0d got %0d", e.tag, tag_out); error_count++;
        end
        if (slot_out !== e.slot) begin
          $error("slot_out exp %0d got %0d", e.slot, slot_out); error_count++;
        end
        if (entry_count !== e.count) begin
          $error("entry_count exp %0d got %0d", e.count, entry_count); error_count++;
        end
      end
    end
  end

  // a random tag, mostly a present one when asked
  function automatic logic [TAG_W-1:0] pick_tag(bit want_present);
    int unsigned t;
    for (int i = 0; i < 8; i++) begin
      t = $urandom_range(0, TAG_SPACE - 1);
      if (shadow_present_plan[t] == want_present) return TAG_W'(t);
    end
    return TAG_W'(t);
  endfunction

  task automatic plan(heap_cmd_t c);
    cmd_queue = {cmd_queue, c};
    case (c.mode)
      MODE_INSERT:
        if (plan_fill < CAPACITY && !shadow_present_plan[c.tag]) begin
          shadow_present_plan[c.tag] = 1; plan_fill++;
        end
      MODE_EXT_MAX, MODE_EXT_POS:
        if (plan_fill > 0 && (c.mode == MODE_EXT_MAX || c.pos < plan_fill)) plan_fill--;
      default: ;
    endcase
  endtask

  function automatic logic [PRIO_W-1:0] rand_prio();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return $urandom_range(0, 1) ? {PRIO_W{1'b1}} : '0;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int n;
    plan_fill = 0;
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: empty removals, extremes, ties, duplicate tag, absent locate
    plan(make_cmd(MODE_EXT_MAX, 0, 0, 0));
    plan(make_cmd(MODE_EXT_POS, 0, 0, 0));
    plan(make_cmd(MODE_LOCATE, 0, 1023, 0));
    plan(make_cmd(MODE_INSERT, '1, 1023, 1023));
    plan(make_cmd(MODE_INSERT, 0, 0, 0));
    plan(make_cmd(MODE_INSERT, 5, 7, 0));
    plan(make_cmd(MODE_INSERT, 5, 8, 0));
    plan(make_cmd(MODE_INSERT, 5, 9, 0));
    plan(make_cmd(MODE_INSERT, 32'h8000_0000, 341, 682));
    plan(make_cmd(MODE_INSERT, 9, 7, 0));
    plan(make_cmd(MODE_LOCATE, 0, 7, 0));
    plan(make_cmd(MODE_LOCATE, 0, 500, 0));
    plan(make_cmd(MODE_EXT_POS, 0, 0, 1023));
    plan(make_cmd(MODE_EXT_POS, 0, 0, 6));
    plan(make_cmd(MODE_EXT_POS, 0, 0, 5));
    plan(make_cmd(MODE_EXT_POS, 0, 0, 1));
    plan(make_cmd(MODE_EXT_MAX, 0, 0, 0));
    plan(make_cmd(MODE_EXT_POS, 0, 0, 0));
    plan(make_cmd(MODE_EXT_MAX, 0, 0, 0));
    plan(make_cmd(MODE_EXT_MAX, 0, 0, 0));
    plan(make_cmd(MODE_EXT_MAX, 0, 0, 0));

    // random phase: fill and drain in waves, with one deep fill to capacity
    n = 0;
    while (n < 1530) begin
      int unsigned r, target;
      if (n == 400) begin
        // every tag once leaves all tags present, so the heap is full
        for (int t = 0; t < TAG_SPACE; t++) plan(make_cmd(MODE_INSERT, rand_prio(), t, 0));
        plan(make_cmd(MODE_INSERT, rand_prio(), $urandom_range(0, TAG_SPACE - 1), 0));
        plan_fill = CAPACITY;
        foreach (shadow_present_plan[i]) shadow_present_plan[i] = 1;
        n += TAG_SPACE + 1;
      end
      target = (n > 200 && n < 1400 && $urandom_range(0, 3) == 0) ? 1 : 0;
      r = $urandom_range(0, 99);
      if (r < 45 || target) plan(make_cmd(MODE_INSERT, rand_prio(), pick_tag(0),
                                          $urandom_range(0, 1023)));
      else if (r < 65) plan(make_cmd(MODE_EXT_MAX, $urandom(), $urandom_range(0, 1023),
                                     $urandom_range(0, 1023)));
      else if (r < 82) plan(make_cmd(MODE_EXT_POS, $urandom(), $urandom_range(0, 1023),
                         (plan_fill > 0 && $urandom_range(0, 5) != 0) ?
                         $urandom_range(0, plan_fill - 1) : $urandom_range(0, 1023)));
      else plan(make_cmd(MODE_LOCATE, $urandom(), pick_tag($urandom_range(0, 3) != 0),
                         $urandom_range(0, 1023)));
      n++;
    end
    stim_done = 1;
  end

  // end of run: queue drained, then a latency pause
  initial begin
    while (!(stim_done && cmd_queue.size() == 0 && reply_queue.size() == 0 && !start))
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0 && reply_queue.size() == 0)
      $display("tb_indexed_max_heap_unit: done, clean");
    else
      $display("tb_indexed_max_heap_unit: done, errors");
    $finish;
  end

  initial begin
    #10000000;
    $display("tb_indexed_max_heap_unit: done, errors");
    $finish;
  end

endmodule
